/* rtl/prq_pkg.sv */
`default_nettype none

package prq_pkg;

    localparam int KIND_W = 2;
    localparam int TID_W = 3;
    localparam int LEVEL_W = 4;
    localparam int STATUS_W = 2;
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUT   = 2'd0,
        KIND_GET   = 2'd1,
        KIND_SCHED = 2'd2,
        KIND_RSVD  = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE    = 2'd0,
        STAT_EMPTY   = 2'd1,
        STAT_READY   = 2'd2,
        STAT_INVALID = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_cur_ctl;

    typedef struct packed {
        logic in_range;
        logic last;
    } t_cur_sts;

endpackage

`default_nettype wire

/* rtl/priority_ready_queue_scheduler.sv */
// Channel  Direction  Ports                    Contents
// s        in         i_s_tvalid/o_s_tready    tdata: thread_id, level; tuser: kind
// m        out        o_m_tvalid/i_m_tready    tdata: picked_thread, status
// A put, a get or an unused kind passes the execute and done states to its result.
// A schedule walks the levels one per cycle with the shared level cursor, from level zero
// up to the lowest non-empty level, or to the last level when every level is empty.
// A new request is accepted once the sequencer is idle, even while a result still waits.
// Reset clears the ready marks, the non-empty bits and both handshakes.
`default_nettype none

module priority_ready_queue_scheduler #(
    parameter int THREADS = 6,
    parameter int PRIORITIES = 16
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_s_tvalid,
    output logic                             o_s_tready,
    // [2:0] thread_id, [6:3] level, [7] zero
    input  wire  [prq_pkg::S_DATA_W-1:0]     i_s_tdata,
    // [1:0] kind
    input  wire  [prq_pkg::KIND_W-1:0]       i_s_tuser,
    output logic                             o_m_tvalid,
    input  wire                              i_m_tready,
    // [2:0] picked_thread, [4:3] status, [7:5] zero
    output logic [prq_pkg::M_DATA_W-1:0]     o_m_tdata
);

    localparam int TW = $clog2(THREADS);
    localparam int LW = $clog2(PRIORITIES);

    prq_pkg::t_state   r_state;
    prq_pkg::t_state   n_state;
    prq_pkg::t_kind    r_kind;
    logic [prq_pkg::TID_W-1:0] r_tid;

    prq_pkg::t_cur_ctl cur_ctl;
    prq_pkg::t_cur_sts cur_sts;
    logic [LW-1:0]     cur_lvl;
    logic [prq_pkg::LEVEL_W-1:0] load_lvl;

    logic              r_ready [THREADS];
    logic [TW-1:0]     r_link [THREADS];
    logic [TW-1:0]     r_head [PRIORITIES];
    logic [TW-1:0]     r_tail [PRIORITIES];
    logic              r_nonempty [PRIORITIES];

    logic [prq_pkg::TID_W-1:0] r_pick;
    logic [prq_pkg::TID_W-1:0] n_pick;
    prq_pkg::t_status  r_stat;
    prq_pkg::t_status  n_stat;
    logic              res_we;

    logic [prq_pkg::TID_W-1:0] r_m_pick;
    prq_pkg::t_status  r_m_stat;
    logic              r_m_valid;
    logic              out_load;

    logic              s_accept;
    logic              tid_ok;
    logic [TW-1:0]     tidx;
    logic [TW-1:0]     head_cur;
    logic [TW-1:0]     tail_cur;
    logic              ne_cur;

    logic              we_link;
    logic              we_head_put;
    logic              we_head_get;
    logic              we_tail;
    logic              set_ne;
    logic              clr_ne;
    logic              set_rdy;
    logic              clr_rdy;

    assign o_s_tready = i_rst_n && (r_state == prq_pkg::ST_IDLE);
    assign s_accept = i_s_tvalid && o_s_tready;
    assign load_lvl = (prq_pkg::t_kind'(i_s_tuser) == prq_pkg::KIND_SCHED)
        ? '0 : i_s_tdata[6:3];

    prq_cursor #(
        .PRIORITIES(PRIORITIES)
    ) u_cursor (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (cur_ctl),
        .i_load_lvl(load_lvl),
        .o_lvl     (cur_lvl),
        .o_sts     (cur_sts)
    );

    assign tid_ok = ({1'b0, r_tid} < (prq_pkg::TID_W + 1)'(THREADS));
    assign tidx = r_tid[TW-1:0];
    assign head_cur = r_head[cur_lvl];
    assign tail_cur = r_tail[cur_lvl];
    assign ne_cur = r_nonempty[cur_lvl];

    always_comb begin
        n_state = r_state;
        cur_ctl = '0;
        n_pick = '0;
        n_stat = prq_pkg::STAT_DONE;
        res_we = 1'b0;
        out_load = 1'b0;
        we_link = 1'b0;
        we_head_put = 1'b0;
        we_head_get = 1'b0;
        we_tail = 1'b0;
        set_ne = 1'b0;
        clr_ne = 1'b0;
        set_rdy = 1'b0;
        clr_rdy = 1'b0;
        unique case (r_state)
            prq_pkg::ST_IDLE: begin
                if (s_accept) begin
                    cur_ctl.load = 1'b1;
                    if (prq_pkg::t_kind'(i_s_tuser) == prq_pkg::KIND_SCHED) begin
                        n_state = prq_pkg::ST_SCAN;
                    end else begin
                        n_state = prq_pkg::ST_EXEC;
                    end
                end
            end
            prq_pkg::ST_EXEC: begin
                res_we = 1'b1;
                n_state = prq_pkg::ST_DONE;
                unique case (r_kind)
                    prq_pkg::KIND_PUT: begin
                        priority if (!tid_ok || !cur_sts.in_range) begin
                            n_stat = prq_pkg::STAT_INVALID;
                        end else if (r_ready[tidx]) begin
                            n_stat = prq_pkg::STAT_READY;
                        end else begin
                            we_link = ne_cur;
                            we_head_put = !ne_cur;
                            set_ne = !ne_cur;
                            we_tail = 1'b1;
                            set_rdy = 1'b1;
                        end
                    end
                    prq_pkg::KIND_GET: begin
                        if (!cur_sts.in_range || !ne_cur) begin
                            n_stat = prq_pkg::STAT_EMPTY;
                        end else begin
                            clr_ne = (head_cur == tail_cur);
                            we_head_get = (head_cur != tail_cur);
                            clr_rdy = 1'b1;
                            n_pick = prq_pkg::TID_W'(head_cur);
                        end
                    end
                    default: begin
                        n_stat = prq_pkg::STAT_INVALID;
                    end
                endcase
            end
            prq_pkg::ST_SCAN: begin
                priority if (ne_cur) begin
                    res_we = 1'b1;
                    n_pick = prq_pkg::TID_W'(head_cur);
                    n_state = prq_pkg::ST_DONE;
                end else if (cur_sts.last) begin
                    res_we = 1'b1;
                    n_stat = prq_pkg::STAT_EMPTY;
                    n_state = prq_pkg::ST_DONE;
                end else begin
                    cur_ctl.step = 1'b1;
                end
            end
            prq_pkg::ST_DONE: begin
                if (!r_m_valid || i_m_tready) begin
                    out_load = 1'b1;
                    n_state = prq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = prq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= prq_pkg::ST_IDLE;
            r_m_valid <= 1'b0;
            for (int i = 0; i < THREADS; i++) begin
                r_ready[i] <= 1'b0;
            end
            for (int j = 0; j < PRIORITIES; j++) begin
                r_nonempty[j] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            if (set_rdy) begin
                r_ready[tidx] <= 1'b1;
            end
            if (clr_rdy) begin
                r_ready[head_cur] <= 1'b0;
            end
            if (set_ne) begin
                r_nonempty[cur_lvl] <= 1'b1;
            end
            if (clr_ne) begin
                r_nonempty[cur_lvl] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_kind <= prq_pkg::t_kind'(i_s_tuser);
            r_tid <= i_s_tdata[2:0];
        end
        if (res_we) begin
            r_pick <= n_pick;
            r_stat <= n_stat;
        end
        if (out_load) begin
            r_m_pick <= r_pick;
            r_m_stat <= r_stat;
        end
        if (we_link) begin
            r_link[tail_cur] <= tidx;
        end
        if (we_head_put) begin
            r_head[cur_lvl] <= tidx;
        end
        if (we_head_get) begin
            r_head[cur_lvl] <= r_link[head_cur];
        end
        if (we_tail) begin
            r_tail[cur_lvl] <= tidx;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata = {3'b000, r_m_stat, r_m_pick};

    a_pick_only_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tdata[2:0] != 3'b000))
            |-> (prq_pkg::t_status'(o_m_tdata[4:3]) == prq_pkg::STAT_DONE))
        else $error("nonzero thread reported with a failing status");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> (r_state != prq_pkg::ST_IDLE))
        else $error("sequencer stayed idle after taking a request");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == prq_pkg::ST_SCAN) |-> cur_sts.in_range)
        else $error("level walk ran past the last level");

    a_done_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (o_m_tvalid && (r_state == prq_pkg::ST_IDLE)))
        else $error("result was not presented after completion");

endmodule

`default_nettype wire

/* rtl/prq_cursor.sv */
`default_nettype none

module prq_cursor #(
    parameter int PRIORITIES = 16
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  prq_pkg::t_cur_ctl                  i_ctl,
    input  wire  [prq_pkg::LEVEL_W-1:0]        i_load_lvl,
    output logic [$clog2(PRIORITIES)-1:0]      o_lvl,
    output prq_pkg::t_cur_sts                  o_sts
);

    localparam int LW = $clog2(PRIORITIES);

    logic [prq_pkg::LEVEL_W-1:0] r_lvl;
    logic [prq_pkg::LEVEL_W-1:0] n_lvl;

    always_comb begin
        n_lvl = r_lvl;
        if (i_ctl.load) begin
            n_lvl = i_load_lvl;
        end else if (i_ctl.step) begin
            n_lvl = r_lvl + prq_pkg::LEVEL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvl <= '0;
        end else begin
            r_lvl <= n_lvl;
        end
    end

    assign o_lvl = r_lvl[LW-1:0];
    assign o_sts.in_range = ({1'b0, r_lvl} < (prq_pkg::LEVEL_W + 1)'(PRIORITIES));
    assign o_sts.last = ({1'b0, r_lvl} == (prq_pkg::LEVEL_W + 1)'(PRIORITIES - 1));

endmodule

`default_nettype wire
